@@ hw/rtl/pdls_pkg.sv @@
`default_nettype none

package pdls_pkg;

	// Command codes carried on the op field
	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_HALT   = 3'd1,
		OP_STEP   = 3'd2,
		OP_SETBRK = 3'd3,
		OP_MEMRD  = 3'd4,
		OP_BRKRD  = 3'd5,
		OP_START  = 3'd6,
		OP_STOP   = 3'd7
	} op_t;

	// The sequencer is idle when no command is loaded (shares the tick code)
	localparam op_t CMD_IDLE = OP_TICK;

	localparam int OP_W        = 3;
	localparam int ADDR_W      = 13;
	localparam int UNIT_W      = 16;
	localparam int READ_W      = 13;
	localparam int SLOT_W      = 6;

	localparam int BREAK_ADDR_BITS_DEF = 13;
	localparam int LONG_WAIT_UNITS_DEF = 8;

	// Memory read layout: 22 send slots, one long wait, 16 read slots
	localparam int MEM_SEND_SLOTS = 22;
	localparam int MEM_READ_SLOTS = 16;
	localparam int MEM_ADDR_HI    = 8;

	typedef struct packed {
		logic              clock_level;
		logic              data_drive;
		logic              data_out;
		logic              run_line;
		logic              busy_res;
		logic              done_res;
		logic [READ_W-1:0] read_data;
	} res_t;

endpackage

`default_nettype wire

@@ hw/rtl/pic_debug_link_sequencer_top.sv @@
`default_nettype none

// Channel  | handshake            | beat contents
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_stall  | op, addr, data_in
// out      | out_valid / out_stall| clock_level, data_drive, data_out, run_line,
//          |                      | busy_res, done_res, read_data
// cfg      | cfg_we               | cfg_data (unit_ticks)
//
// One input beat is taken per clock while in_stall is low; its result beat is registered into the output queue.
// Sequencer state updates on the input beat, the result lands in a 2-deep
// output queue, so in_stall rises only when that queue is full.
// Reset: idle, clock low, host drives data, target held, unit_ticks = 1.
// Result beats keep their order and none are dropped across stalls.

module pic_debug_link_sequencer_top
	import pdls_pkg::*;
#(
	parameter int BREAK_ADDR_BITS = BREAK_ADDR_BITS_DEF,
	parameter int LONG_WAIT_UNITS = LONG_WAIT_UNITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic              data_in,
	input  wire logic              cfg_we,
	input  wire logic [UNIT_W-1:0] cfg_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   clock_level,
	output logic                   data_drive,
	output logic                   data_out,
	output logic                   run_line,
	output logic                   busy_res,
	output logic                   done_res,
	output logic [READ_W-1:0]      read_data
);

	// Slot counts and counter widths derived from the parameters and package constants
	localparam int SEND_SLOTS   = 4 + 2 * BREAK_ADDR_BITS;
	localparam int BRKRD_SLOTS  = 2 * BREAK_ADDR_BITS;
	localparam int MEM_RD_FIRST = MEM_SEND_SLOTS + 1;
	localparam int MEM_RD_END   = MEM_SEND_SLOTS + 1 + MEM_READ_SLOTS;
	localparam int UNITS_W      = $clog2(LONG_WAIT_UNITS + 3);
	localparam int WAIT_W       = $clog2(LONG_WAIT_UNITS * 65535 + 1);
	localparam int CNT_W        = $clog2(BREAK_ADDR_BITS + 1);

	// ---------------- configuration ----------------
	logic [UNIT_W-1:0] unit_ticks_q;
	logic [UNIT_W-1:0] ut_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= UNIT_W'(1);
		end else if (cfg_we) begin
			unit_ticks_q <= cfg_data;
		end
	end

	// a zero unit count behaves as one tick
	assign ut_eff = (unit_ticks_q == '0) ? UNIT_W'(1) : unit_ticks_q;

	// ---------------- sequencer state ----------------
	op_t               cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [WAIT_W-1:0] wait_q;
	logic [ADDR_W-1:0] shift_q;
	logic [READ_W-1:0] accum_q;
	logic [CNT_W-1:0]  rcnt_q;
	logic              clk_lvl_q;
	logic              drive_q;
	logic              dout_q;
	logic              run_q;

	logic        in_acc;
	logic        out_pop;
	op_t         op_in;

	assign op_in  = op_t'(op);
	assign in_acc = in_valid && !in_stall;

	// next-state values
	op_t               cmd_d;
	logic [SLOT_W-1:0] slot_d;
	logic [WAIT_W-1:0] wait_d;
	logic [ADDR_W-1:0] shift_d;
	logic [READ_W-1:0] accum_d;
	logic [CNT_W-1:0]  rcnt_d;
	logic              clk_lvl_d;
	logic              drive_d;
	logic              dout_d;
	logic              run_d;
	logic              done_d;

	// slot engine inputs
	logic              do_slot;
	op_t               s_cmd;
	logic [SLOT_W-1:0] s_idx;
	logic [UNITS_W-1:0] s_units;
	logic              s_take;
	logic [WAIT_W-1:0] wait_dec;
	logic [SLOT_W-1:0] r_idx;

	assign wait_dec = (wait_q != '0) ? (wait_q - WAIT_W'(1)) : '0;

	always_comb begin
		cmd_d     = cmd_q;
		slot_d    = slot_q;
		wait_d    = wait_q;
		shift_d   = shift_q;
		accum_d   = accum_q;
		rcnt_d    = rcnt_q;
		clk_lvl_d = clk_lvl_q;
		drive_d   = drive_q;
		dout_d    = dout_q;
		run_d     = run_q;
		done_d    = 1'b0;
		do_slot   = 1'b0;
		s_cmd     = cmd_q;
		s_idx     = slot_q;
		s_units   = '0;
		s_take    = 1'b0;
		r_idx     = '0;

		// pick up a new command or advance on a tick
		if (cmd_q == CMD_IDLE) begin
			if (op_in != OP_TICK) begin
				do_slot = 1'b1;
				s_cmd   = op_in;
				s_idx   = '0;
				cmd_d   = op_in;
				slot_d  = '0;
				shift_d = addr;
				if (op_in == OP_MEMRD || op_in == OP_BRKRD) begin
					accum_d = '0;
					rcnt_d  = '0;
				end
			end
		end else if (op_in == OP_TICK) begin
			wait_d = wait_dec;
			if (wait_dec == '0) begin
				do_slot = 1'b1;
				s_idx   = slot_q + SLOT_W'(1);
				slot_d  = s_idx;
			end
		end

		if (do_slot) begin
			unique case (s_cmd)
				OP_HALT: begin
					if (s_idx < SLOT_W'(2)) begin
						clk_lvl_d = !clk_lvl_q;
						s_units   = UNITS_W'(1);
					end
				end
				OP_STEP: begin
					if (s_idx == SLOT_W'(0)) begin
						clk_lvl_d = !clk_lvl_q;
						drive_d   = 1'b1;
						s_units   = UNITS_W'(1);
					end else if (s_idx == SLOT_W'(1)) begin
						dout_d    = 1'b0;
						clk_lvl_d = !clk_lvl_q;
						s_units   = UNITS_W'(1);
					end else begin
						drive_d = 1'b0;
					end
				end
				OP_SETBRK: begin
					if (s_idx < SLOT_W'(SEND_SLOTS)) begin
						clk_lvl_d = !clk_lvl_q;
						if (s_idx == SLOT_W'(0)) drive_d = 1'b1;
						if (!s_idx[0]) begin
							if (s_idx < SLOT_W'(4)) begin
								dout_d = 1'b1;
							end else begin
								dout_d  = shift_d[0];
								shift_d = shift_d >> 1;
							end
						end
						s_units = UNITS_W'(1);
					end else if (s_idx == SLOT_W'(SEND_SLOTS)) begin
						s_units = UNITS_W'(LONG_WAIT_UNITS);
					end else begin
						drive_d = 1'b0;
					end
				end
				OP_MEMRD: begin
					if (s_idx < SLOT_W'(MEM_SEND_SLOTS)) begin
						clk_lvl_d = !clk_lvl_q;
						if (s_idx == SLOT_W'(0)) drive_d = 1'b1;
						if (!s_idx[0]) begin
							if (s_idx == SLOT_W'(0)) begin
								dout_d = 1'b1;
							end else if (s_idx == SLOT_W'(2)) begin
								dout_d = 1'b0;
							end else if (s_idx == SLOT_W'(4)) begin
								dout_d = shift_d[MEM_ADDR_HI];
							end else begin
								dout_d  = shift_d[0];
								shift_d = shift_d >> 1;
							end
						end
						s_units = UNITS_W'(LONG_WAIT_UNITS);
					end else if (s_idx == SLOT_W'(MEM_SEND_SLOTS)) begin
						s_units = UNITS_W'(LONG_WAIT_UNITS);
					end else if (s_idx < SLOT_W'(MEM_RD_END)) begin
						r_idx = s_idx - SLOT_W'(MEM_RD_FIRST);
						if (r_idx == '0) drive_d = 1'b0;
						clk_lvl_d = !clk_lvl_q;
						s_take    = r_idx[0];
						s_units   = UNITS_W'(LONG_WAIT_UNITS);
					end
				end
				OP_BRKRD: begin
					if (s_idx < SLOT_W'(BRKRD_SLOTS)) begin
						clk_lvl_d = !clk_lvl_q;
						s_take    = s_idx[0];
						s_units   = UNITS_W'(1);
					end
				end
				OP_START: begin
					if (s_idx == SLOT_W'(0)) begin
						run_d   = 1'b0;
						s_units = UNITS_W'(2);
					end else if (s_idx == SLOT_W'(1)) begin
						drive_d = 1'b0;
						s_units = UNITS_W'(2);
					end else begin
						run_d = 1'b1;
					end
				end
				OP_STOP: begin
					run_d   = 1'b0;
					drive_d = 1'b1;
				end
				default: begin
					s_units = '0;
				end
			endcase

			// sampled bits land LSB first; bits past the result width drop off
			if (s_take) begin
				accum_d = accum_d | (READ_W'(data_in) << rcnt_d);
				rcnt_d  = rcnt_d + CNT_W'(1);
			end

			if (s_units == '0) begin
				cmd_d  = CMD_IDLE;
				wait_d = '0;
				done_d = 1'b1;
			end else begin
				wait_d = WAIT_W'(s_units) * WAIT_W'(ut_eff);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= CMD_IDLE;
			slot_q    <= '0;
			wait_q    <= '0;
			shift_q   <= '0;
			accum_q   <= '0;
			rcnt_q    <= '0;
			clk_lvl_q <= 1'b0;
			drive_q   <= 1'b1;
			dout_q    <= 1'b0;
			run_q     <= 1'b0;
		end else if (in_acc) begin
			cmd_q     <= cmd_d;
			slot_q    <= slot_d;
			wait_q    <= wait_d;
			shift_q   <= shift_d;
			accum_q   <= accum_d;
			rcnt_q    <= rcnt_d;
			clk_lvl_q <= clk_lvl_d;
			drive_q   <= drive_d;
			dout_q    <= dout_d;
			run_q     <= run_d;
		end
	end

	// ---------------- result queue (two beats) ----------------
	res_t       res_d;
	res_t       res_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	res_t       res_head;

	always_comb begin
		res_d.clock_level = clk_lvl_d;
		res_d.data_drive  = drive_d;
		res_d.data_out    = dout_d;
		res_d.run_line    = run_d;
		res_d.busy_res    = (cmd_d != CMD_IDLE);
		res_d.done_res    = done_d;
		res_d.read_data   = accum_d;
	end

	assign out_pop   = out_valid && !out_stall;
	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q[wptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (in_acc) wptr_q <= !wptr_q;
			if (out_pop) rptr_q <= !rptr_q;
			if (in_acc && !out_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (out_pop && !in_acc) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign res_head    = res_q[rptr_q];
	assign clock_level = res_head.clock_level;
	assign data_drive  = res_head.data_drive;
	assign data_out    = res_head.data_out;
	assign run_line    = res_head.run_line;
	assign busy_res    = res_head.busy_res;
	assign done_res    = res_head.done_res;
	assign read_data   = res_head.read_data;

	// ---------------- assertions ----------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_busy_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q != CMD_IDLE |-> wait_q != '0)
		else $error("busy with no wait pending");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> !busy_res)
		else $error("done beat reports busy");

	a_cmd_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cmd_q == CMD_IDLE && op_in != OP_TICK && op_in != OP_STOP)
		|=> cmd_q != CMD_IDLE)
		else $error("command did not start");

endmodule

`default_nettype wire
